// ----- hdl/cfdf_pkg.sv -----
// Shared types and constants of the CRC-checked frame deframer.
package cfdf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_LEN_RESET = 8'd250;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_LEN = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRCLO   = 3'd5,
        PH_CRCHI   = 3'd6
    } cfdf_phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_GOOD   = 3'd2,
        EV_CRCERR = 3'd3,
        EV_LENREJ = 3'd4
    } cfdf_event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] max_payload_len;
    } cfdf_cfg_t;

    typedef struct packed {
        cfdf_event_t       event_res;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_length;
    } cfdf_result_t;

endpackage

// ----- hdl/crc_checked_frame_deframer_top.sv -----
// Top level of the CRC-checked frame deframer: input register, parser, result register.
//
// The block parses a received byte stream into frames made of two sync bytes, a length,
// a type, the payload and a CRC16-CCITT sent low byte first. Every accepted byte gives
// exactly one result transfer: payload bytes stream out with their index, and the last CRC
// byte reports a good frame or a CRC error. It takes one byte per clock cycle when the
// output side keeps up; a byte passes through the input register and then the result
// register. The CRC of a byte is computed combinationally by an unrolled eight-step XOR
// network. Configuration writes are always accepted and should be made while no byte
// is in flight.
module crc_checked_frame_deframer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cfdf_pkg::BYTE_W-1:0]       rx_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        event_res,
    output logic [cfdf_pkg::BYTE_W-1:0]       data_byte,
    output logic [cfdf_pkg::BYTE_W-1:0]       byte_index,
    output logic [cfdf_pkg::BYTE_W-1:0]       frame_type,
    output logic [cfdf_pkg::BYTE_W-1:0]       frame_length,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cfdf_pkg::BYTE_W-1:0]       cfg_data
);
    import cfdf_pkg::*;

    cfdf_cfg_t         cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              out_valid_reg;
    cfdf_result_t      out_result_reg;
    cfdf_result_t      step_result;
    logic              step_en;

    // A byte moves from the input register to the result register when the latter is free.
    assign step_en   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first      <= SYNC_FIRST_RESET;
            cfg_reg.sync_second     <= SYNC_SECOND_RESET;
            cfg_reg.max_payload_len <= MAX_PAYLOAD_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SYNC_FIRST)
            begin
                cfg_reg.sync_first <= cfg_data;
            end
            if (cfg_index == CFG_SYNC_SECOND)
            begin
                cfg_reg.sync_second <= cfg_data;
            end
            if (cfg_index == CFG_MAX_PAYLOAD_LEN)
            begin
                cfg_reg.max_payload_len <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= rx_data;
        end
        if (step_en)
        begin
            out_result_reg <= step_result;
        end
    end

    cfdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    assign out_valid    = out_valid_reg;
    assign event_res    = out_result_reg.event_res;
    assign data_byte    = out_result_reg.data_byte;
    assign byte_index   = out_result_reg.byte_index;
    assign frame_type   = out_result_reg.frame_type;
    assign frame_length = out_result_reg.frame_length;

    a_step_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg
    ) else $error("parsed byte did not reach the result register");

    a_full_pipe_stalls_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready
    ) else $error("input taken while both registers are held");

endmodule

// ----- hdl/cfdf_crc.sv -----
// One-byte CRC16-CCITT update, MSB first, as an unrolled eight-step XOR network.
module cfdf_crc (
    input  logic [cfdf_pkg::CRC_W-1:0]  crc_in,
    input  logic [cfdf_pkg::BYTE_W-1:0] data,
    output logic [cfdf_pkg::CRC_W-1:0]  crc_out
);
    import cfdf_pkg::*;

    logic [CRC_W-1:0] crc_work;

    always_comb
    begin
        crc_work = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (crc_work[CRC_W-1])
            begin
                crc_work = {crc_work[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc_work = {crc_work[CRC_W-2:0], 1'b0};
            end
        end
    end

    assign crc_out = crc_work;

endmodule

// ----- hdl/cfdf_parser.sv -----
// Frame parser state machine: holds the frame state and computes one result per byte.
module cfdf_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic [cfdf_pkg::BYTE_W-1:0]  rx_byte,
    input  cfdf_pkg::cfdf_cfg_t          cfg,
    output cfdf_pkg::cfdf_result_t       result
);
    import cfdf_pkg::*;

    cfdf_phase_t       phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] crc_low_reg, crc_low_next;

    logic [CRC_W-1:0]  crc_seed;
    logic [CRC_W-1:0]  crc_fed;
    logic              length_too_long;

    // The length byte restarts the CRC from its initial value.
    assign crc_seed = (phase_reg == PH_LEN) ? CRC_INIT : crc_reg;
    assign length_too_long = rx_byte > cfg.max_payload_len;

    cfdf_crc u_crc (
        .crc_in  (crc_seed),
        .data    (rx_byte),
        .crc_out (crc_fed)
    );

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC2:   phase_next = (rx_byte == cfg.sync_second) ? PH_LEN : PH_SYNC1;
            PH_LEN:     phase_next = length_too_long ? PH_SYNC1 : PH_TYPE;
            PH_TYPE:    phase_next = (length_reg == '0) ? PH_CRCLO : PH_PAYLOAD;
            PH_PAYLOAD: phase_next = (remaining_reg == BYTE_W'(1)) ? PH_CRCLO : PH_PAYLOAD;
            PH_CRCLO:   phase_next = PH_CRCHI;
            PH_CRCHI:   phase_next = PH_SYNC1;
            default:    phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
        endcase
    end

    // Frame data path and result.
    always_comb
    begin
        length_next    = length_reg;
        type_next      = type_reg;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        crc_low_next   = crc_low_reg;
        result.event_res  = EV_NONE;
        result.data_byte  = '0;
        result.byte_index = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                length_next = rx_byte;
                if (length_too_long)
                begin
                    result.event_res = EV_LENREJ;
                end
                else
                begin
                    crc_next = crc_fed;
                end
            end
            PH_TYPE:
            begin
                type_next      = rx_byte;
                crc_next       = crc_fed;
                remaining_next = length_reg;
            end
            PH_PAYLOAD:
            begin
                result.event_res  = EV_DATA;
                result.data_byte  = rx_byte;
                result.byte_index = length_reg - remaining_reg;
                crc_next          = crc_fed;
                remaining_next    = remaining_reg - BYTE_W'(1);
            end
            PH_CRCLO:
            begin
                crc_low_next = rx_byte;
            end
            PH_CRCHI:
            begin
                // The CRC arrives low byte first.
                result.event_res = ({rx_byte, crc_low_reg} == crc_reg) ? EV_GOOD : EV_CRCERR;
            end
            default:
            begin
            end
        endcase
        result.frame_type   = type_next;
        result.frame_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            length_reg    <= '0;
            type_reg      <= '0;
            remaining_reg <= '0;
            crc_reg       <= CRC_INIT;
            crc_low_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            type_reg      <= type_next;
            remaining_reg <= remaining_next;
            crc_reg       <= crc_next;
            crc_low_reg   <= crc_low_next;
        end
    end

    a_payload_has_bytes_left: assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != '0)
    ) else $error("payload phase with no bytes left");

    a_crc_high_ends_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step_en && phase_reg == PH_CRCHI) |=> (phase_reg == PH_SYNC1)
    ) else $error("parser did not return to hunting after the CRC high byte");

    a_type_step_loads_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step_en && phase_reg == PH_TYPE) |=> (remaining_reg == $past(length_reg))
    ) else $error("byte counter not loaded from the frame length");

endmodule
